FILE: hdl/cpp_pkg.sv
package cpp_pkg;

  // 96 quotient bits of {time, 32'b0} / period; the low 32 are the phase
  localparam int PH_STEPS = 96;
  localparam int MAX_STEPS = 32;
  localparam int ROOT_ITERS = 32;
  localparam int DIV_ITERS = 63;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  typedef logic signed [31:0] unit_t;
  typedef logic signed [33:0] trig_t;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_AXIS_X   = 3'd3,
    REG_AXIS_Y   = 3'd4,
    REG_AXIS_Z   = 3'd5,
    REG_RADIUS   = 3'd6,
    REG_PERIOD   = 3'd7
  } reg_idx_e;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input int i);
    logic [29:0] r;
    case (i)
      0: r = 30'd536870912;
      1: r = 30'd316933406;
      2: r = 30'd167458907;
      3: r = 30'd85004756;
      4: r = 30'd42667331;
      5: r = 30'd21354465;
      6: r = 30'd10679838;
      7: r = 30'd5340245;
      8: r = 30'd2670163;
      9: r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      24: r = 30'd41;
      25: r = 30'd20;
      26: r = 30'd10;
      27: r = 30'd5;
      28: r = 30'd3;
      29: r = 30'd1;
      30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/cpp_phase.sv
module cpp_phase (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  logic [63:0] time_i,
  input  logic [31:0] period_i,
  output logic        vld_o,
  output logic [31:0] ang_o
);
  import cpp_pkg::*;

  logic [32:0] rem_q [PH_STEPS];
  logic [63:0] num_q [PH_STEPS];
  logic [31:0] quo_q [PH_STEPS];
  logic        vld_q [PH_STEPS];

  // one restoring-division bit per stage
  for (genvar s = 0; s < PH_STEPS; s++) begin : g_st
    logic [32:0] rem_p;
    logic [63:0] num_p;
    logic [31:0] quo_p;
    logic        vld_p;
    logic [33:0] r2;
    logic        ge;

    if (s == 0) begin : g_in
      assign rem_p = '0;
      assign num_p = time_i;
      assign quo_p = '0;
      assign vld_p = vld_i;
    end else begin : g_mid
      assign rem_p = rem_q[s-1];
      assign num_p = num_q[s-1];
      assign quo_p = quo_q[s-1];
      assign vld_p = vld_q[s-1];
    end

    assign r2 = {rem_p, num_p[63]};
    assign ge = r2 >= {2'b00, period_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? 33'(r2 - {2'b00, period_i}) : r2[32:0];
      num_q[s] <= {num_p[62:0], 1'b0};
      quo_q[s] <= {quo_p[30:0], ge};
    end
  end

  assign vld_o = vld_q[PH_STEPS-1];
  assign ang_o = (period_i == '0) ? '0 : quo_q[PH_STEPS-1];

endmodule

FILE: hdl/cpp_cordic.sv
module cpp_cordic #(
  parameter int STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [31:0]          ang_i,
  output logic                 vld_o,
  output cpp_pkg::trig_t       cos_o,
  output cpp_pkg::trig_t       sin_o
);
  import cpp_pkg::*;

  trig_t              x_q [STEPS];
  trig_t              y_q [STEPS];
  logic signed [32:0] z_q [STEPS];
  logic [1:0]         quad_q [STEPS];
  logic               vld_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_st
    trig_t              x_p, y_p;
    logic signed [32:0] z_p, at;
    logic [1:0]         quad_p;
    logic               vld_p;

    if (s == 0) begin : g_in
      assign x_p    = CORDIC_X0;
      assign y_p    = '0;
      assign z_p    = $signed({3'b000, ang_i[29:0]});
      assign quad_p = ang_i[31:30];
      assign vld_p  = vld_i;
    end else begin : g_mid
      assign x_p    = x_q[s-1];
      assign y_p    = y_q[s-1];
      assign z_p    = z_q[s-1];
      assign quad_p = quad_q[s-1];
      assign vld_p  = vld_q[s-1];
    end

    assign at = $signed({3'b000, atan_turn(s)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!z_p[32]) begin
        x_q[s] <= x_p - (y_p >>> s);
        y_q[s] <= y_p + (x_p >>> s);
        z_q[s] <= z_p - at;
      end else begin
        x_q[s] <= x_p + (y_p >>> s);
        y_q[s] <= y_p - (x_p >>> s);
        z_q[s] <= z_p + at;
      end
      quad_q[s] <= quad_p;
    end
  end

  always_comb begin
    case (quad_q[STEPS-1])
      2'd0: begin
        cos_o = x_q[STEPS-1];
        sin_o = y_q[STEPS-1];
      end
      2'd1: begin
        cos_o = -y_q[STEPS-1];
        sin_o = x_q[STEPS-1];
      end
      2'd2: begin
        cos_o = -x_q[STEPS-1];
        sin_o = -y_q[STEPS-1];
      end
      default: begin
        cos_o = y_q[STEPS-1];
        sin_o = -x_q[STEPS-1];
      end
    endcase
  end

  assign vld_o = vld_q[STEPS-1];

endmodule

FILE: hdl/cpp_basis.sv
module cpp_basis (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               kick_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output logic               busy_o,
  output cpp_pkg::unit_t     u_o [3],
  output cpp_pkg::unit_t     v_o [3]
);
  import cpp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_SQ   = 6'b000100,
    ST_ROOT = 6'b001000,
    ST_DSET = 6'b010000,
    ST_DIV  = 6'b100000
  } basis_st_e;

  localparam logic signed [31:0] MINUS_ONE = -32'sd1073741824;

  basis_st_e          state_q, state_d;
  logic signed [33:0] vec_q [3], vec_d [3];
  logic signed [33:0] cvec_q [3], cvec_d [3];
  logic               sel_q, sel_d;
  logic [1:0]         k_q, k_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [63:0]        acc_q, acc_d;
  logic [63:0]        n_q, n_d;
  logic [63:0]        res_q, res_d;
  logic [63:0]        bit_q, bit_d;
  logic [32:0]        rem_q, rem_d;
  logic [62:0]        num_q, num_d;
  logic [29:0]        quo_q, quo_d;
  unit_t              u_q [3], u_d [3];
  unit_t              v_q [3], v_d [3];

  logic signed [33:0] ax, ay, az, ur0, ur1;
  logic signed [33:0] cur;
  logic [31:0]        mk;
  logic [63:0]        sq, rt;
  logic [33:0]        r2;
  logic               ge;
  logic [30:0]        qf;
  unit_t              of;

  assign ax = 34'(axis_x_i);
  assign ay = 34'(axis_y_i);
  assign az = 34'(axis_z_i);

  always_comb begin
    if (axis_x_i == '0 && axis_y_i == '0) begin
      ur0 = -az;
      ur1 = '0;
    end else begin
      ur0 = ay;
      ur1 = -ax;
    end
  end

  assign cur = vec_q[k_q];
  assign mk  = cur[33] ? 32'(-cur) : cur[31:0];
  assign sq  = 64'(mk) * 64'(mk);
  assign rt  = res_q + bit_q;
  assign r2  = {rem_q, num_q[62]};
  assign ge  = r2 >= {2'b00, res_q[31:0]};
  assign qf  = {quo_q, ge};
  assign of  = (res_q[31:0] == '0) ? '0 :
               (cur[33] ? -$signed({1'b0, qf}) : $signed({1'b0, qf}));

  always_comb begin
    state_d = state_q;
    vec_d   = vec_q;
    cvec_d  = cvec_q;
    sel_d   = sel_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    n_d     = n_q;
    res_d   = res_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    num_d   = num_q;
    quo_d   = quo_q;
    u_d     = u_q;
    v_d     = v_q;
    unique case (state_q)
      ST_IDLE: begin
        if (kick_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        vec_d[0]  = ur0;
        vec_d[1]  = ur1;
        vec_d[2]  = '0;
        cvec_d[0] = -34'(az * ur1);
        cvec_d[1] = 34'(az * ur0);
        cvec_d[2] = 34'(ax * ur1) - 34'(ay * ur0);
        sel_d     = 1'b0;
        k_d       = '0;
        acc_d     = '0;
        state_d   = ST_SQ;
      end
      ST_SQ: begin
        if (k_q == 2'd2) begin
          n_d     = acc_q + sq;
          res_d   = '0;
          bit_d   = 64'd1 << 62;
          cnt_d   = '0;
          state_d = ST_ROOT;
        end else begin
          acc_d = acc_q + sq;
          k_d   = k_q + 2'd1;
        end
      end
      ST_ROOT: begin
        if (n_q >= rt) begin
          n_d   = n_q - rt;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(ROOT_ITERS - 1)) begin
          k_d     = '0;
          state_d = ST_DSET;
        end
      end
      ST_DSET: begin
        // rounded quotient: (|c| << 30 + norm/2) / norm
        num_d   = {1'b0, mk, 30'd0} + 63'(res_q[31:1]);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? 33'(r2 - {2'b00, res_q[31:0]}) : r2[32:0];
        num_d = {num_q[61:0], 1'b0};
        quo_d = qf[29:0];
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_ITERS - 1)) begin
          if (sel_q) v_d[k_q] = of;
          else u_d[k_q] = of;
          if (k_q == 2'd2) begin
            if (!sel_q) begin
              sel_d   = 1'b1;
              vec_d   = cvec_q;
              acc_d   = '0;
              k_d     = '0;
              state_d = ST_SQ;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            k_d     = k_q + 2'd1;
            state_d = ST_DSET;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a new axis write restarts the rebuild from the updated axis
    if (kick_i) state_d = ST_LOAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 1'b0;
      k_q     <= '0;
      cnt_q   <= '0;
      // basis for the reset axis (0, 0, 1)
      u_q[0]  <= MINUS_ONE;
      u_q[1]  <= '0;
      u_q[2]  <= '0;
      v_q[0]  <= '0;
      v_q[1]  <= MINUS_ONE;
      v_q[2]  <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      u_q     <= u_d;
      v_q     <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= vec_d;
    cvec_q <= cvec_d;
    acc_q  <= acc_d;
    n_q    <= n_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign u_o    = u_q;
  assign v_o    = v_q;

endmodule

FILE: hdl/cpp_combine.sv
module cpp_combine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  cpp_pkg::trig_t     cos_i,
  input  cpp_pkg::trig_t     sin_i,
  input  logic [30:0]        radius_i,
  input  logic signed [31:0] center_i [3],
  input  cpp_pkg::unit_t     u_i [3],
  input  cpp_pkg::unit_t     v_i [3],
  output logic               vld_o,
  output logic signed [31:0] pos_o [3]
);
  import cpp_pkg::*;

  localparam logic signed [65:0] HALF66 = 66'sd536870912;
  localparam logic signed [67:0] HALF68 = 68'sd536870912;
  localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
  localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;

  logic               vld1_q, vld2_q, vld3_q, vld4_q;
  logic signed [65:0] pc_q, ps_q;
  logic signed [33:0] rc_q, rs_q;
  logic signed [65:0] pu_q [3], pv_q [3];
  logic signed [31:0] ctr_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [65:0] rcw, rsw;

  assign rcw = (pc_q + HALF66) >>> 30;
  assign rsw = (ps_q + HALF66) >>> 30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q <= 66'($signed({1'b0, radius_i}) * cos_i);
    ps_q <= 66'($signed({1'b0, radius_i}) * sin_i);
    rc_q <= rcw[33:0];
    rs_q <= rsw[33:0];
  end

  for (genvar k = 0; k < 3; k++) begin : g_ax
    logic signed [67:0] acc;
    logic signed [67:0] accs;
    logic signed [37:0] p;

    assign acc  = (68'(ctr_q[k]) <<< 30) + 68'(pu_q[k]) + 68'(pv_q[k]) + HALF68;
    assign accs = acc >>> 30;
    assign p    = accs[37:0];

    always_ff @(posedge clk_i) begin
      pu_q[k]  <= 66'(rc_q * u_i[k]);
      pv_q[k]  <= 66'(rs_q * v_i[k]);
      ctr_q[k] <= center_i[k];
      if (p > SAT_MAX) pos_q[k] <= SAT_MAX[31:0];
      else if (p < SAT_MIN) pos_q[k] <= SAT_MIN[31:0];
      else pos_q[k] <= p[31:0];
    end
  end

  assign vld_o = vld4_q;
  assign pos_o = pos_q;

endmodule

FILE: hdl/circle_path_position.sv
// Channel    Direction  Ports                                   Transfer
// command    in         start, busy, time_ticks_i               start & !busy
// result     out        done_o, pos_x_o, pos_y_o, pos_z_o       one-cycle strobe
// config     in         cfg_we_i, cfg_idx_i, cfg_wdata_i        cfg_we_i
//
// One transaction per cycle while busy is low. The pipeline holds 96 long-division
// stages for the phase, one CORDIC stage per step (at most 32 steps), and four
// for scale, multiply-add and saturation.
// A write to an axis register raises busy while the basis vectors are rebuilt by
// one shared square-root and divide unit; a later axis write restarts the rebuild.
// Reset is asynchronous; no result waits for the receiver, so nothing stalls.
module circle_path_position #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] time_ticks_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o
);
  import cpp_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  logic signed [31:0] center_q [3];
  logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;
  logic [30:0]        radius_q;
  logic [31:0]        period_q;
  logic               kick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      axis_x_q    <= '0;
      axis_y_q    <= '0;
      axis_z_q    <= 16'sd16384;
      radius_q    <= 31'd65536;
      period_q    <= 32'd1000;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CENTER_X: center_q[0] <= cfg_wdata_i;
        REG_CENTER_Y: center_q[1] <= cfg_wdata_i;
        REG_CENTER_Z: center_q[2] <= cfg_wdata_i;
        REG_AXIS_X:   axis_x_q    <= cfg_wdata_i[15:0];
        REG_AXIS_Y:   axis_y_q    <= cfg_wdata_i[15:0];
        REG_AXIS_Z:   axis_z_q    <= cfg_wdata_i[15:0];
        REG_RADIUS:   radius_q    <= cfg_wdata_i[30:0];
        REG_PERIOD:   period_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign kick = cfg_we_i && (reg_idx_e'(cfg_idx_i) == REG_AXIS_X ||
                             reg_idx_e'(cfg_idx_i) == REG_AXIS_Y ||
                             reg_idx_e'(cfg_idx_i) == REG_AXIS_Z);

  logic        ph_vld;
  logic [31:0] ang;
  logic        tr_vld;
  trig_t       cs, sn;
  unit_t       u [3], v [3];
  logic signed [31:0] pos [3];

  cpp_basis u_basis (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .kick_i   (kick),
    .axis_x_i (axis_x_q),
    .axis_y_i (axis_y_q),
    .axis_z_i (axis_z_q),
    .busy_o   (busy),
    .u_o      (u),
    .v_o      (v)
  );

  cpp_phase u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (start && !busy),
    .time_i   (time_ticks_i),
    .period_i (period_q),
    .vld_o    (ph_vld),
    .ang_o    (ang)
  );

  cpp_cordic #(
    .STEPS (NSTEP)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (ph_vld),
    .ang_i  (ang),
    .vld_o  (tr_vld),
    .cos_o  (cs),
    .sin_o  (sn)
  );

  cpp_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (tr_vld),
    .cos_i    (cs),
    .sin_i    (sn),
    .radius_i (radius_q),
    .center_i (center_q),
    .u_i      (u),
    .v_i      (v),
    .vld_o    (done_o),
    .pos_o    (pos)
  );

  assign pos_x_o = pos[0];
  assign pos_y_o = pos[1];
  assign pos_z_o = pos[2];

endmodule
